@@ rtl/core/gb2312_font_rom_addresser_macros.svh @@
// ============================================================================
// GB2312 font ROM addresser assertion macros
// Concurrent assertion wrappers; the bodies are empty in synthesis builds.
// ============================================================================
`ifndef GB2312_FONT_ROM_ADDRESSER_MACROS_SVH
`define GB2312_FONT_ROM_ADDRESSER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every clock edge outside reset
`define GFRA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every clock edge outside reset
`define GFRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define GFRA_ASSERT_SAME(label, clk, rst, ante, cons)
`define GFRA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/gfra_pkg.sv @@
// ============================================================================
// GB2312 font ROM addresser package
// Code ranges, font ROM base addresses, glyph kinds and register indexes.
// ============================================================================
`default_nettype none

package gfra_pkg;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_FONT_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_COLUMN = 2'd1;

  // Reset values of the registers
  localparam logic       FONT_MODE_RESET    = 1'b0;
  localparam logic [7:0] START_COLUMN_RESET = 8'd1;

  // Byte code ranges
  localparam logic [7:0] CODE_TERMINATOR = 8'h00;
  localparam logic [7:0] HANZI_LEAD_LO   = 8'hB0;
  localparam logic [7:0] HANZI_LEAD_HI   = 8'hF7;
  localparam logic [7:0] SYM_LEAD_LO     = 8'hA1;
  localparam logic [7:0] SYM_LEAD_HI     = 8'hA3;
  localparam logic [7:0] TRAIL_LO        = 8'hA1;
  localparam logic [7:0] ASCII_LO        = 8'h20;
  localparam logic [7:0] ASCII_HI        = 8'h7E;

  // Glyph index arithmetic
  localparam int unsigned IDX_W = 13;
  localparam logic [IDX_W-1:0] ROW_SIZE     = 13'd94;
  localparam logic [IDX_W-1:0] HANZI_OFFSET = 13'd846;

  // Font ROM layout
  localparam int unsigned ADDR_W = 18;
  localparam logic [ADDR_W-1:0] NARROW_BASE = 18'h3CF80;
  localparam logic [ADDR_W-1:0] SMALL_BASE  = 18'h3BFC0;

  // Glyph kinds
  localparam logic [1:0] KIND_WIDE   = 2'd0;
  localparam logic [1:0] KIND_NARROW = 2'd1;
  localparam logic [1:0] KIND_SMALL  = 2'd2;

  // Bytes per glyph bitmap
  localparam logic [5:0] COUNT_WIDE   = 6'd32;
  localparam logic [5:0] COUNT_NARROW = 6'd16;
  localparam logic [5:0] COUNT_SMALL  = 6'd8;

  // Column advance per glyph
  localparam logic [7:0] STEP_WIDE   = 8'd16;
  localparam logic [7:0] STEP_NARROW = 8'd8;
  localparam logic [7:0] STEP_SMALL  = 8'd6;

  // One glyph request
  typedef struct packed {
    logic [ADDR_W-1:0] rom_address;
    logic [5:0]        read_count;
    logic [1:0]        glyph_kind;
    logic [7:0]        glyph_column;
  } glyph_req_t;

endpackage

`default_nettype wire

@@ rtl/core/gb2312_font_rom_addresser.sv @@
// ============================================================================
// GB2312 font ROM addresser
// Turns a text byte stream into font ROM glyph requests with display columns.
// ============================================================================
// Takes one text byte per clock cycle while text_ready is high, and returns at
// most one glyph request per byte in the next cycle from one output register. A
// GB2312 code needs two bytes (lead, then trail) and yields its request after
// the trail byte; lead bytes, terminators and dropped bytes yield nothing.
// The lead byte, its pending flag and the running column sit in registers that
// update as each byte is taken, so the next byte can follow in the very next
// cycle; the output register is the only stage, and text_ready stays high while
// the held request is empty or being taken. Write configuration only while no
// request is outstanding; writing start_column also resets the running column.
`default_nettype none

`include "gb2312_font_rom_addresser_macros.svh"

module gb2312_font_rom_addresser (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [gfra_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [7:0]                          cfg_data,
  // Text byte channel
  input  wire logic                                text_valid,
  output logic                                     text_ready,
  input  wire logic [7:0]                          text_byte,
  // Glyph request channel
  output logic                                     glyph_valid,
  input  wire logic                                glyph_ready,
  output logic [gfra_pkg::ADDR_W-1:0]              rom_address,
  output logic [5:0]                               read_count,
  output logic [1:0]                               glyph_kind,
  output logic [7:0]                               glyph_column
);

  // Configuration and running state
  logic       font_mode;
  logic [7:0] start_column;
  logic [7:0] lead_byte;
  logic       lead_pending;
  logic [7:0] next_column;

  logic [7:0] lead_byte_next;
  logic       lead_pending_next;
  logic [7:0] next_column_next;

  // Result register
  gfra_pkg::glyph_req_t glyph;
  gfra_pkg::glyph_req_t glyph_next;
  logic                 emit;

  logic text_accept;
  logic cfg_accept;

  // Byte classification
  logic       is_term;
  logic       is_ascii;
  logic       is_lead;
  logic       is_trail;
  logic       lead_is_hanzi;
  logic [7:0] lead_off;
  logic [7:0] trail_off;
  logic [7:0] ascii_off;
  logic [gfra_pkg::IDX_W-1:0] glyph_idx;

  assign cfg_ready   = 1'b1;
  assign cfg_accept  = cfg_valid && cfg_ready;
  assign text_ready  = !glyph_valid || glyph_ready;
  assign text_accept = text_valid && text_ready;

  // Classify the incoming byte
  assign is_term  = (text_byte == gfra_pkg::CODE_TERMINATOR);
  assign is_ascii = (text_byte >= gfra_pkg::ASCII_LO) && (text_byte <= gfra_pkg::ASCII_HI);
  assign is_lead  = ((text_byte >= gfra_pkg::HANZI_LEAD_LO) &&
                     (text_byte <= gfra_pkg::HANZI_LEAD_HI)) ||
                    ((text_byte >= gfra_pkg::SYM_LEAD_LO) &&
                     (text_byte <= gfra_pkg::SYM_LEAD_HI));
  assign is_trail = (text_byte >= gfra_pkg::TRAIL_LO);

  // Form the double-byte glyph index from the stored lead and this trail
  assign lead_is_hanzi = (lead_byte >= gfra_pkg::HANZI_LEAD_LO);
  assign lead_off      = lead_is_hanzi ? (lead_byte - gfra_pkg::HANZI_LEAD_LO)
                                       : (lead_byte - gfra_pkg::SYM_LEAD_LO);
  assign trail_off     = text_byte - gfra_pkg::TRAIL_LO;
  assign ascii_off     = text_byte - gfra_pkg::ASCII_LO;
  assign glyph_idx     = gfra_pkg::IDX_W'(lead_off[6:0]) * gfra_pkg::ROW_SIZE
                       + gfra_pkg::IDX_W'(trail_off)
                       + (lead_is_hanzi ? gfra_pkg::HANZI_OFFSET : '0);

  // Decode one byte into a request and the next state
  always_comb begin
    lead_byte_next    = lead_byte;
    lead_pending_next = lead_pending;
    next_column_next  = next_column;
    emit              = 1'b0;
    glyph_next.rom_address  = '0;
    glyph_next.read_count   = gfra_pkg::COUNT_WIDE;
    glyph_next.glyph_kind   = gfra_pkg::KIND_WIDE;
    glyph_next.glyph_column = next_column;

    if (font_mode) begin
      // Small ASCII only; drop any pending lead
      lead_pending_next = 1'b0;
      if (is_term) begin
        next_column_next = start_column;
      end else if (is_ascii) begin
        emit = 1'b1;
        glyph_next.rom_address = gfra_pkg::SMALL_BASE + (gfra_pkg::ADDR_W'(ascii_off[6:0]) << 3);
        glyph_next.read_count  = gfra_pkg::COUNT_SMALL;
        glyph_next.glyph_kind  = gfra_pkg::KIND_SMALL;
        next_column_next       = next_column + gfra_pkg::STEP_SMALL;
      end
    end else if (lead_pending && is_trail) begin
      // Complete the double-byte code
      lead_pending_next = 1'b0;
      emit = 1'b1;
      glyph_next.rom_address = gfra_pkg::ADDR_W'({glyph_idx, 5'b00000});
      glyph_next.read_count  = gfra_pkg::COUNT_WIDE;
      glyph_next.glyph_kind  = gfra_pkg::KIND_WIDE;
      next_column_next       = next_column + gfra_pkg::STEP_WIDE;
    end else begin
      // Fresh byte, including a rejected trail
      lead_pending_next = 1'b0;
      if (is_term) begin
        next_column_next = start_column;
      end else if (is_lead) begin
        lead_byte_next    = text_byte;
        lead_pending_next = 1'b1;
      end else if (is_ascii) begin
        emit = 1'b1;
        glyph_next.rom_address = gfra_pkg::NARROW_BASE + (gfra_pkg::ADDR_W'(ascii_off[6:0]) << 4);
        glyph_next.read_count  = gfra_pkg::COUNT_NARROW;
        glyph_next.glyph_kind  = gfra_pkg::KIND_NARROW;
        next_column_next       = next_column + gfra_pkg::STEP_NARROW;
      end
    end
  end

  // Update configuration and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      font_mode    <= gfra_pkg::FONT_MODE_RESET;
      start_column <= gfra_pkg::START_COLUMN_RESET;
      lead_byte    <= '0;
      lead_pending <= 1'b0;
      next_column  <= gfra_pkg::START_COLUMN_RESET;
    end else begin
      if (text_accept) begin
        lead_byte    <= lead_byte_next;
        lead_pending <= lead_pending_next;
      end
      // A start column write takes precedence over the column advance
      if (cfg_accept && (cfg_index == gfra_pkg::REG_START_COLUMN)) begin
        next_column <= cfg_data;
      end else if (text_accept) begin
        next_column <= next_column_next;
      end
      if (cfg_accept) begin
        unique case (cfg_index)
          gfra_pkg::REG_FONT_MODE: begin
            font_mode <= cfg_data[0];
          end
          gfra_pkg::REG_START_COLUMN: begin
            start_column <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Hold the request until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_valid <= 1'b0;
    end else if (text_accept && emit) begin
      glyph_valid <= 1'b1;
    end else if (glyph_ready) begin
      glyph_valid <= 1'b0;
    end
  end

  // Load the request payload
  always_ff @(posedge clk) begin
    if (text_accept && emit) begin
      glyph <= glyph_next;
    end
  end

  assign rom_address  = glyph.rom_address;
  assign read_count   = glyph.read_count;
  assign glyph_kind   = glyph.glyph_kind;
  assign glyph_column = glyph.glyph_column;

  // Checks
  `GFRA_ASSERT_SAME(a_count_matches_kind, clk, rst, glyph_valid,
    ((glyph_kind == gfra_pkg::KIND_WIDE) && (read_count == gfra_pkg::COUNT_WIDE)) ||
    ((glyph_kind == gfra_pkg::KIND_NARROW) && (read_count == gfra_pkg::COUNT_NARROW)) ||
    ((glyph_kind == gfra_pkg::KIND_SMALL) && (read_count == gfra_pkg::COUNT_SMALL)))
  `GFRA_ASSERT_NEXT(a_term_restarts_column, clk, rst,
    text_accept && (text_byte == gfra_pkg::CODE_TERMINATOR), next_column == start_column)
  `GFRA_ASSERT_NEXT(a_small_mode_no_lead, clk, rst, text_accept && font_mode, !lead_pending)

endmodule

`default_nettype wire

@@ verif/glyph_check_pkg.sv @@
// ============================================================================
// Glyph request tracker
// Predicts the glyph requests of the font ROM addresser from the accepted text
// bytes and register writes, and checks each observed request against them.
// ============================================================================
package glyph_check_pkg;

  import gfra_pkg::*;

  localparam int MAX_REPORTS = 10;

  class glyph_tracker;

    logic       font_mode;
    logic [7:0] start_column;
    logic [7:0] lead_byte;
    bit         lead_pending;
    logic [7:0] next_column;
    glyph_req_t pending_glyphs[$];
    int         mismatches;

    function new();
      font_mode    = FONT_MODE_RESET;
      start_column = START_COLUMN_RESET;
      lead_byte    = '0;
      lead_pending = 1'b0;
      next_column  = START_COLUMN_RESET;
      mismatches   = 0;
    endfunction

    // Apply one register write; unmapped indexes change nothing
    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [7:0] data);
      case (index)
        REG_FONT_MODE: begin
          font_mode = data[0];
        end
        REG_START_COLUMN: begin
          start_column = data;
          next_column  = data;
        end
        default: begin
        end
      endcase
    endfunction

    // Queue one request at the running column, then advance the column
    function void queue_glyph(int addr, logic [5:0] count, logic [1:0] kind,
                              logic [7:0] step);
      glyph_req_t req;
      req.rom_address  = ADDR_W'(addr);
      req.read_count   = count;
      req.glyph_kind   = kind;
      req.glyph_column = next_column;
      pending_glyphs.push_back(req);
      next_column = next_column + step;
    endfunction

    // Work out the request, if any, caused by one accepted text byte
    function void take_byte(logic [7:0] code);
      int row;
      int cell_idx;
      // 5x7 mode: any pending lead is dropped
      if (font_mode) begin
        lead_pending = 1'b0;
        if (code == CODE_TERMINATOR)
          next_column = start_column;
        else if (code >= ASCII_LO && code <= ASCII_HI)
          queue_glyph(int'(SMALL_BASE) + (int'(code) - int'(ASCII_LO)) * 8,
                      COUNT_SMALL, KIND_SMALL, STEP_SMALL);
        return;
      end
      // Trail byte completes a double-byte code
      if (lead_pending) begin
        lead_pending = 1'b0;
        if (code >= TRAIL_LO) begin
          if (lead_byte >= HANZI_LEAD_LO) begin
            row      = int'(lead_byte) - int'(HANZI_LEAD_LO);
            cell_idx = row * int'(ROW_SIZE) + int'(code) - int'(TRAIL_LO)
                       + int'(HANZI_OFFSET);
          end else begin
            row      = int'(lead_byte) - int'(SYM_LEAD_LO);
            cell_idx = row * int'(ROW_SIZE) + int'(code) - int'(TRAIL_LO);
          end
          queue_glyph(cell_idx * 32, COUNT_WIDE, KIND_WIDE, STEP_WIDE);
          return;
        end
        // a bad trail falls through and is handled as a fresh byte
      end
      if (code == CODE_TERMINATOR) begin
        next_column = start_column;
      end else if ((code >= HANZI_LEAD_LO && code <= HANZI_LEAD_HI) ||
                   (code >= SYM_LEAD_LO && code <= SYM_LEAD_HI)) begin
        lead_byte    = code;
        lead_pending = 1'b1;
      end else if (code >= ASCII_LO && code <= ASCII_HI) begin
        queue_glyph(int'(NARROW_BASE) + (int'(code) - int'(ASCII_LO)) * 16,
                    COUNT_NARROW, KIND_NARROW, STEP_NARROW);
      end
    endfunction

    // Compare an observed request with the oldest prediction
    function void check_request(glyph_req_t seen);
      glyph_req_t want;
      if (pending_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected glyph request: addr=%h count=%0d kind=%0d col=%0d",
                   seen.rom_address, seen.read_count, seen.glyph_kind,
                   seen.glyph_column);
        return;
      end
      want = pending_glyphs.pop_front();
      if (seen.rom_address !== want.rom_address || seen.read_count !== want.read_count ||
          seen.glyph_kind !== want.glyph_kind || seen.glyph_column !== want.glyph_column)
      begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("glyph mismatch: expected addr=%h count=%0d kind=%0d col=%0d, got addr=%h count=%0d kind=%0d col=%0d",
                   want.rom_address, want.read_count, want.glyph_kind, want.glyph_column,
                   seen.rom_address, seen.read_count, seen.glyph_kind, seen.glyph_column);
      end
    endfunction

    function int outstanding();
      return pending_glyphs.size();
    endfunction

  endclass

endpackage

@@ verif/tb.sv @@
// ============================================================================
// Font ROM addresser testbench
// Feeds directed and random text through both font modes and several start
// columns, with random sender gaps and receiver stalls, and checks every
// glyph request against a predicted copy of the addresser state.
// ============================================================================
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import gfra_pkg::*;
  import glyph_check_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASES        = 8;
  localparam int PHASE_BYTES   = 200;
  localparam int CYCLE_LIMIT   = 300000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]             cfg_data;
  logic                   text_valid;
  logic                   text_ready;
  logic [7:0]             text_byte;
  logic                   glyph_valid;
  logic                   glyph_ready;
  logic [ADDR_W-1:0]      rom_address;
  logic [5:0]             read_count;
  logic [1:0]             glyph_kind;
  logic [7:0]             glyph_column;

  glyph_tracker glyph_book;
  bit           hold_request;
  int           burst_left;
  int           bytes_sent;

  // Edges and special codes of the double-byte and ASCII ranges, mode 0
  logic [7:0] wide_text[$] = '{
    ASCII_LO, ASCII_HI, ASCII_LO - 8'd1, ASCII_HI + 8'd1, 8'h80, 8'hFF, 8'hA4,
    HANZI_LEAD_LO, TRAIL_LO, HANZI_LEAD_HI, 8'hFE, SYM_LEAD_LO, TRAIL_LO,
    SYM_LEAD_HI, 8'hFF, HANZI_LEAD_LO, 8'h41, SYM_LEAD_HI, 8'hA0,
    HANZI_LEAD_LO + 8'd5, CODE_TERMINATOR, 8'h30
  };

  // 5x7 range edges and dropped bytes, mode 1
  logic [7:0] small_text[$] = '{
    8'h41, ASCII_LO, ASCII_HI, 8'h80, HANZI_LEAD_LO, CODE_TERMINATOR, 8'h7F, 8'h5A
  };

  gb2312_font_rom_addresser i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .glyph_valid  (glyph_valid),
    .glyph_ready  (glyph_ready),
    .rom_address  (rom_address),
    .read_count   (read_count),
    .glyph_kind   (glyph_kind),
    .glyph_column (glyph_column)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch every transaction; check results before noting the new byte
  always @(posedge clk) begin
    if (!rst) begin
      if (glyph_valid && glyph_ready)
        glyph_book.check_request(glyph_req_t'{rom_address, read_count, glyph_kind,
                                              glyph_column});
      if (cfg_valid && cfg_ready)
        glyph_book.write_reg(cfg_index, cfg_data);
      if (text_valid && text_ready)
        glyph_book.take_byte(text_byte);
    end
  end

  // Receiver: stall patterns in segments, plus a long hold on request
  initial begin
    int style;
    int seg_len;
    int period;
    int tick;
    int held;
    glyph_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        glyph_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++)
          @(negedge clk);
      end
      style   = $urandom_range(3);
      seg_len = $urandom_range(200, 10);
      period  = $urandom_range(5, 2);
      for (tick = 0; tick < seg_len; tick++) begin
        case (style)
          0: glyph_ready <= 1'b1;
          1: glyph_ready <= 1'($urandom_range(1));
          2: glyph_ready <= ($urandom_range(9) != 0);
          default: glyph_ready <= (tick % period != 0);
        endcase
        @(negedge clk);
        if (hold_request)
          break;
      end
    end
  end

  // Offer one byte and hold it until taken; valid stays high
  task automatic send_byte(input logic [7:0] value);
    text_valid <= 1'b1;
    text_byte  <= value;
    do @(posedge clk); while (!text_ready);
    @(negedge clk);
  endtask

  // Send in bursts of random length with random gaps between them
  task automatic send_paced(input logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        text_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    send_byte(value);
    bytes_sent++;
  endtask

  // Stop sending until every predicted request has come out
  task automatic wait_for_glyphs();
    text_valid <= 1'b0;
    burst_left = 0;
    while (glyph_book.outstanding() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-formed characters with random content, some noise and bad pairs
  task automatic send_random_text(input logic mode);
    int pick;
    pick = $urandom_range(99);
    if (!mode) begin
      if (pick < 40) begin
        send_paced(8'($urandom_range(HANZI_LEAD_HI, HANZI_LEAD_LO)));
        send_paced(8'($urandom_range(8'hFF, TRAIL_LO)));
      end else if (pick < 50) begin
        send_paced(8'($urandom_range(SYM_LEAD_HI, SYM_LEAD_LO)));
        send_paced(8'($urandom_range(8'hFF, TRAIL_LO)));
      end else if (pick < 75) begin
        send_paced(8'($urandom_range(ASCII_HI, ASCII_LO)));
      end else if (pick < 80) begin
        send_paced(CODE_TERMINATOR);
      end else if (pick < 88) begin
        // lead followed by a trail below the valid range
        if ($urandom_range(1))
          send_paced(8'($urandom_range(HANZI_LEAD_HI, HANZI_LEAD_LO)));
        else
          send_paced(8'($urandom_range(SYM_LEAD_HI, SYM_LEAD_LO)));
        send_paced(8'($urandom_range(TRAIL_LO - 8'd1, 0)));
      end else begin
        send_paced(8'($urandom_range(255)));
      end
    end else begin
      if (pick < 75)
        send_paced(8'($urandom_range(ASCII_HI, ASCII_LO)));
      else if (pick < 82)
        send_paced(CODE_TERMINATOR);
      else if (pick < 90)
        send_paced(8'($urandom_range(HANZI_LEAD_HI, SYM_LEAD_LO)));
      else
        send_paced(8'($urandom_range(255)));
    end
  endtask

  // Run limit
  initial begin
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
      @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    int         phase;
    logic       mode;
    logic [7:0] column;
    glyph_book   = new();
    hold_request = 1'b0;
    burst_left   = 0;
    bytes_sent   = 0;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = REG_FONT_MODE;
    cfg_data     = '0;
    text_valid   = 1'b0;
    text_byte    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed text at the reset settings, ending on a pending lead
    foreach (wide_text[i])
      send_paced(wide_text[i]);
    send_paced(HANZI_LEAD_HI);
    wait_for_glyphs();

    // Switch to 5x7 with the lead still pending; poke unmapped registers
    write_register(REG_SPARE_A, 8'($urandom_range(255)));
    write_register(REG_FONT_MODE, 8'h01);
    write_register(REG_START_COLUMN, 8'hFF);
    write_register(REG_SPARE_B, 8'($urandom_range(255)));
    foreach (small_text[i])
      send_paced(small_text[i]);

    // Random phases, each at its own settings
    for (phase = 0; phase < PHASES; phase++) begin
      wait_for_glyphs();
      mode = (phase == 3 || phase == 6) ? 1'b1 : ($urandom_range(4) == 0);
      if (phase == 0)
        column = 8'h00;
      else if (phase == 1)
        column = 8'hFF;
      else
        column = 8'($urandom_range(255));
      if ($urandom_range(1))
        write_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                       8'($urandom_range(255)));
      write_register(REG_FONT_MODE, {7'($urandom_range(127)), mode});
      write_register(REG_START_COLUMN, column);
      // block the output for a long stretch while text keeps coming
      if (phase == 2)
        hold_request = 1'b1;
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) begin
        send_random_text(mode);
        if ($urandom_range(99) == 0)
          wait_for_glyphs();
      end
    end

    wait_for_glyphs();
    if (glyph_book.mismatches == 0 && glyph_book.outstanding() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
